[rtl/qfmd_pkg.sv]
// Package for the quadrature FM discriminator.
// Holds the CORDIC angle table, fixed-point widths and the pipeline tag type.
// No dependencies.
package qfmd_pkg;

  localparam int ATAN_LEN    = 24;
  localparam int ANGLE_W     = 33;
  localparam int PHASE_W     = 17;
  localparam int SENS_W      = 16;
  localparam int SENS_FRAC   = 12;
  localparam int FREQ_W      = 20;
  localparam int ROUND_SHIFT = 16;
  localparam int PHASE_LIMIT = 32768;

  localparam logic signed [SENS_W-1:0]  SENS_RESET = 16'sd4096;
  localparam logic signed [ANGLE_W-1:0] HALF_PI    = 33'sh040000000;

  localparam logic signed [ANGLE_W-1:0] ATAN_STEPS [ATAN_LEN] = '{
    33'sh020000000, 33'sh012E4051E, 33'sh009FB385B, 33'sh0051111D4,
    33'sh0028B0D43, 33'sh00145D7E1, 33'sh000A2F61E, 33'sh000517C55,
    33'sh00028BE53, 33'sh000145F2F, 33'sh0000A2F98, 33'sh0000517CC,
    33'sh000028BE6, 33'sh0000145F3, 33'sh000000A2FA, 33'sh00000517D,
    33'sh0000028BE, 33'sh00000145F, 33'sh000000A30, 33'sh000000518,
    33'sh00000028C, 33'sh000000146, 33'sh0000000A3, 33'sh000000051
  };

  typedef struct packed {
    logic valid;
    logic zero;
    logic last;
  } tag_t;

endpackage

[rtl/qfmd_prod.sv]
// Front end of the discriminator: conjugate product and quadrant pre-rotation.
// Three register stages feeding the CORDIC cell chain. Uses qfmd_pkg.
module qfmd_prod import qfmd_pkg::*; #(
  parameter int SW = 16,
  parameter int XW = 35
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  tag_t                      tag_in,
  input  logic signed [SW-1:0]      cur_i,
  input  logic signed [SW-1:0]      cur_q,
  input  logic signed [SW-1:0]      prev_i,
  input  logic signed [SW-1:0]      prev_q,
  output tag_t                      tag_out,
  output logic signed [XW-1:0]      x_out,
  output logic signed [XW-1:0]      y_out,
  output logic signed [ANGLE_W-1:0] z_out
);

  tag_t                     tag_a_r, tag_b_r, tag_c_r;
  logic signed [2*SW-1:0]   p_ii_r, p_qq_r, p_qi_r, p_iq_r;
  logic signed [XW-1:0]     re_r, im_r;
  logic signed [XW-1:0]     x_r, y_r;
  logic signed [ANGLE_W-1:0] z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
      tag_b_r <= '0;
      tag_c_r <= '0;
    end else if (en) begin
      tag_a_r <= tag_in;
      tag_b_r <= tag_a_r;
      tag_c_r <= '{valid: tag_b_r.valid,
                   zero:  (re_r == '0) && (im_r == '0),
                   last:  tag_b_r.last};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ii_r <= cur_i * prev_i;
      p_qq_r <= cur_q * prev_q;
      p_qi_r <= cur_q * prev_i;
      p_iq_r <= cur_i * prev_q;
      re_r   <= XW'(p_ii_r) + XW'(p_qq_r);
      im_r   <= XW'(p_qi_r) - XW'(p_iq_r);
      if (re_r[XW-1]) begin
        if (!im_r[XW-1]) begin
          x_r <= im_r;
          y_r <= -re_r;
          z_r <= HALF_PI;
        end else begin
          x_r <= -im_r;
          y_r <= re_r;
          z_r <= -HALF_PI;
        end
      end else begin
        x_r <= re_r;
        y_r <= im_r;
        z_r <= '0;
      end
    end
  end

  assign tag_out = tag_c_r;
  assign x_out   = x_r;
  assign y_out   = y_r;
  assign z_out   = z_r;

endmodule

[rtl/qfmd_cell.sv]
// One CORDIC vectoring cell: a single rotation step with registered outputs.
// Cells that differ only in STAGE form the chain in the top level. Uses qfmd_pkg.
module qfmd_cell import qfmd_pkg::*; #(
  parameter int XW    = 35,
  parameter int STAGE = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  tag_t                      tag_in,
  input  logic signed [XW-1:0]      x_in,
  input  logic signed [XW-1:0]      y_in,
  input  logic signed [ANGLE_W-1:0] z_in,
  output tag_t                      tag_out,
  output logic signed [XW-1:0]      x_out,
  output logic signed [XW-1:0]      y_out,
  output logic signed [ANGLE_W-1:0] z_out
);

  tag_t                      tag_r;
  logic signed [XW-1:0]      x_r, y_r;
  logic signed [ANGLE_W-1:0] z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (en) begin
      tag_r <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[XW-1]) begin
        x_r <= x_in + (y_in >>> STAGE);
        y_r <= y_in - (x_in >>> STAGE);
        z_r <= z_in + ATAN_STEPS[STAGE];
      end else begin
        x_r <= x_in - (y_in >>> STAGE);
        y_r <= y_in + (x_in >>> STAGE);
        z_r <= z_in - ATAN_STEPS[STAGE];
      end
    end
  end

  assign tag_out = tag_r;
  assign x_out   = x_r;
  assign y_out   = y_r;
  assign z_out   = z_r;

endmodule

[rtl/qfmd_scale.sv]
// Back end of the discriminator: angle rounding, clamping and sensitivity gain.
// Its second stage is the output register of the block. Uses qfmd_pkg.
module qfmd_scale import qfmd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  tag_t                      tag_in,
  input  logic signed [ANGLE_W-1:0] z_in,
  input  logic signed [SENS_W-1:0]  sens,
  output logic                      valid,
  output logic signed [FREQ_W-1:0]  freq,
  output logic                      last
);

  localparam logic signed [ANGLE_W-1:0] ROUND_BIAS = ANGLE_W'(2 ** (ROUND_SHIFT - 1));
  localparam logic signed [ANGLE_W-1:0] CLAMP_HI   = ANGLE_W'(PHASE_LIMIT);
  localparam logic signed [ANGLE_W-1:0] CLAMP_LO   = -ANGLE_W'(PHASE_LIMIT);

  tag_t                             tag_d_r, tag_e_r;
  logic signed [ANGLE_W-1:0]        rounded;
  logic signed [PHASE_W-1:0]        phase_nxt, phase_r;
  logic signed [PHASE_W+SENS_W-1:0] product;
  logic signed [FREQ_W-1:0]         freq_r;

  always_comb begin
    rounded = (z_in + ROUND_BIAS) >>> ROUND_SHIFT;
    if (tag_in.zero) begin
      phase_nxt = '0;
    end else if (rounded > CLAMP_HI) begin
      phase_nxt = CLAMP_HI[PHASE_W-1:0];
    end else if (rounded < CLAMP_LO) begin
      phase_nxt = CLAMP_LO[PHASE_W-1:0];
    end else begin
      phase_nxt = rounded[PHASE_W-1:0];
    end
    product = phase_r * sens;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_d_r <= '0;
      tag_e_r <= '0;
    end else if (en) begin
      tag_d_r <= tag_in;
      tag_e_r <= tag_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phase_r <= phase_nxt;
      freq_r  <= product[SENS_FRAC+FREQ_W-1:SENS_FRAC];
    end
  end

  assign valid = tag_e_r.valid;
  assign freq  = freq_r;
  assign last  = tag_e_r.last;

endmodule

[rtl/quadrature_fm_discriminator.sv]
// Quadrature FM discriminator: takes complex baseband words in bursts and
// returns the scaled phase step between neighbouring samples of a burst.
// The data path is a single pipeline that advances whenever the output register
// is empty or its word is being taken, so one word is accepted per cycle in
// steady state. A result passes through three front-end stages, one CORDIC cell
// per stage (at most 24) and two scaling stages, the first loaded at the edge
// that accepts its sample. The first sample of a burst produces no result. Uses
// qfmd_pkg and the qfmd_prod, qfmd_cell and qfmd_scale modules.
module quadrature_fm_discriminator import qfmd_pkg::*; #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic signed [SENS_W-1:0]      cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_q,
  input  logic                          in_first_of_burst,
  input  logic                          in_last_of_burst,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [FREQ_W-1:0]      out_freq_value,
  output logic                          out_last_result
);

  localparam int XW    = 2 * SAMPLE_WIDTH + 3;
  localparam int CELLS = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

  logic                           advance;
  logic                           accept;
  logic signed [SENS_W-1:0]       sens_r;
  logic signed [SAMPLE_WIDTH-1:0] prev_i_r, prev_q_r;
  logic                           have_prev_r;
  tag_t                           in_tag;

  tag_t                      chain_tag [CELLS+1];
  logic signed [XW-1:0]      chain_x   [CELLS+1];
  logic signed [XW-1:0]      chain_y   [CELLS+1];
  logic signed [ANGLE_W-1:0] chain_z   [CELLS+1];

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && advance;

  always_comb begin
    in_tag.valid = accept && !in_first_of_burst && have_prev_r;
    in_tag.zero  = 1'b0;
    in_tag.last  = in_last_of_burst;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r      <= SENS_RESET;
      prev_i_r    <= '0;
      prev_q_r    <= '0;
      have_prev_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        sens_r <= cfg_wdata;
      end
      if (accept) begin
        prev_i_r    <= in_i;
        prev_q_r    <= in_q;
        have_prev_r <= !in_last_of_burst;
      end
    end
  end

  qfmd_prod #(
    .SW (SAMPLE_WIDTH),
    .XW (XW)
  ) u_prod (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .tag_in  (in_tag),
    .cur_i   (in_i),
    .cur_q   (in_q),
    .prev_i  (prev_i_r),
    .prev_q  (prev_q_r),
    .tag_out (chain_tag[0]),
    .x_out   (chain_x[0]),
    .y_out   (chain_y[0]),
    .z_out   (chain_z[0])
  );

  for (genvar s = 0; s < CELLS; s++) begin : g_cell
    qfmd_cell #(
      .XW    (XW),
      .STAGE (s)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (advance),
      .tag_in  (chain_tag[s]),
      .x_in    (chain_x[s]),
      .y_in    (chain_y[s]),
      .z_in    (chain_z[s]),
      .tag_out (chain_tag[s+1]),
      .x_out   (chain_x[s+1]),
      .y_out   (chain_y[s+1]),
      .z_out   (chain_z[s+1])
    );
  end

  qfmd_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (advance),
    .tag_in (chain_tag[CELLS]),
    .z_in   (chain_z[CELLS]),
    .sens   (sens_r),
    .valid  (out_valid),
    .freq   (out_freq_value),
    .last   (out_last_result)
  );

endmodule

[dv/qfmd_checker.sv]
// Checker for the quadrature FM discriminator: watches the sample, result and
// sensitivity ports, predicts every result word with a CORDIC model of its own
// and compares it field by field. Uses qfmd_pkg for the port widths.
module qfmd_checker import qfmd_pkg::*; #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic signed [SENS_W-1:0]       cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_q,
  input  logic                           in_first_of_burst,
  input  logic                           in_last_of_burst,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [FREQ_W-1:0]       out_freq_value,
  input  logic                           out_last_result,
  output int                             fault_count,
  output int                             awaited_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     ARC_LEN      = 24;
  localparam int     STAGES_USED  = (CORDIC_STAGES > ARC_LEN) ? ARC_LEN : CORDIC_STAGES;
  localparam longint QUARTER_TURN = 64'sd1073741824;

  localparam longint ARC_TABLE [ARC_LEN] = '{
    64'sh20000000, 64'sh12E4051E, 64'sh09FB385B, 64'sh051111D4,
    64'sh028B0D43, 64'sh0145D7E1, 64'sh00A2F61E, 64'sh00517C55,
    64'sh0028BE53, 64'sh00145F2F, 64'sh000A2F98, 64'sh000517CC,
    64'sh00028BE6, 64'sh000145F3, 64'sh0000A2FA, 64'sh0000517D,
    64'sh000028BE, 64'sh0000145F, 64'sh00000A30, 64'sh00000518,
    64'sh0000028C, 64'sh00000146, 64'sh000000A3, 64'sh00000051
  };

  typedef struct {
    logic signed [FREQ_W-1:0] freq;
    logic                     burst_end;
  } freq_word_t;

  freq_word_t awaited_words [$];
  longint     gain;
  longint     held_i;
  longint     held_q;
  logic       burst_open;

  // Vectoring CORDIC on the conjugate product, giving 32768 per pi.
  function automatic longint cordic_phase(longint re, longint im);
    longint x, y, z, t, xs, ys;
    int k;
    if (re == 0 && im == 0) return 0;
    x = re;
    y = im;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = QUARTER_TURN;
      end else begin
        t = x; x = -y; y = t; z = -QUARTER_TURN;
      end
    end
    for (k = 0; k < STAGES_USED; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + ARC_TABLE[k];
      end else begin
        x = x - ys; y = y + xs; z = z - ARC_TABLE[k];
      end
    end
    z = (z + 32768) >>> 16;
    if (z > 32768) z = 32768;
    if (z < -32768) z = -32768;
    return z;
  endfunction

  function automatic freq_word_t predict_freq(longint ci, longint cq, logic burst_end);
    freq_word_t w;
    longint re, im, scaled;
    re = ci * held_i + cq * held_q;
    im = cq * held_i - ci * held_q;
    scaled = (cordic_phase(re, im) * gain) >>> 12;
    w.freq = scaled[FREQ_W-1:0];
    w.burst_end = burst_end;
    return w;
  endfunction

  initial begin
    fault_count = 0;
    awaited_count = 0;
    gain = 4096;
    held_i = 0;
    held_q = 0;
    burst_open = 1'b0;
  end

  always @(posedge clk) begin
    freq_word_t got, want;
    longint ci, cq;
    if (!rst_n) begin
      gain = 4096;
      held_i = 0;
      held_q = 0;
      burst_open = 1'b0;
      awaited_words.delete();
    end else begin
      if (cfg_we) gain = cfg_wdata;
      if (out_valid && out_ready) begin
        got.freq = out_freq_value;
        got.burst_end = out_last_result;
        if (awaited_words.size() == 0) begin
          $error("unexpected result word: freq_value %0d last_result %0b",
                 got.freq, got.burst_end);
          fault_count++;
        end else begin
          want = awaited_words.pop_front();
          if (got.freq !== want.freq) begin
            $error("freq_value: expected %0d, actual %0d", want.freq, got.freq);
            fault_count++;
          end
          if (got.burst_end !== want.burst_end) begin
            $error("last_result: expected %0b, actual %0b", want.burst_end, got.burst_end);
            fault_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        ci = in_i;
        cq = in_q;
        if (!in_first_of_burst && burst_open)
          awaited_words.push_back(predict_freq(ci, cq, in_last_of_burst));
        held_i = ci;
        held_q = cq;
        burst_open = !in_last_of_burst;
      end
    end
    awaited_count = awaited_words.size();
  end

endmodule

[dv/quadrature_fm_discriminator_tb.sv]
// Top of the quadrature FM discriminator testbench: makes the clock, reset,
// sensitivity writes and sample bursts, and gives the verdict.
// Depends on qfmd_pkg, the discriminator RTL and qfmd_checker.
module quadrature_fm_discriminator_tb import qfmd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W  = 16;
  localparam int STAGES    = 16;
  localparam int SETTLE    = STAGES + 12;
  localparam int SEG_ITEMS = 275;

  typedef struct {
    logic signed [SAMPLE_W-1:0] i;
    logic signed [SAMPLE_W-1:0] q;
    logic                       is_first;
    logic                       is_last;
  } sample_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic signed [SENS_W-1:0]   cfg_wdata;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_i;
  logic signed [SAMPLE_W-1:0] in_q;
  logic                       in_first_of_burst;
  logic                       in_last_of_burst;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [FREQ_W-1:0]   out_freq_value;
  logic                       out_last_result;
  int                         fault_count;
  int                         awaited_count;
  int                         tx_idle_pct;
  int                         rx_idle_pct;

  quadrature_fm_discriminator #(
    .SAMPLE_WIDTH (SAMPLE_W),
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_i             (in_i),
    .in_q             (in_q),
    .in_first_of_burst(in_first_of_burst),
    .in_last_of_burst (in_last_of_burst),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_freq_value   (out_freq_value),
    .out_last_result  (out_last_result)
  );

  qfmd_checker #(
    .SAMPLE_WIDTH (SAMPLE_W),
    .CORDIC_STAGES(STAGES)
  ) checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_i             (in_i),
    .in_q             (in_q),
    .in_first_of_burst(in_first_of_burst),
    .in_last_of_burst (in_last_of_burst),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_freq_value   (out_freq_value),
    .out_last_result  (out_last_result),
    .fault_count      (fault_count),
    .awaited_count    (awaited_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] extremes [5];
    extremes = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001};
    case ($urandom_range(7))
      0: begin
        return extremes[$urandom_range(4)];
      end
      1: begin
        return SAMPLE_W'($urandom_range(255) - 128);
      end
      default: begin
        return SAMPLE_W'($urandom());
      end
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(sample_t s);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_i <= s.i;
    in_q <= s.q;
    in_first_of_burst <= s.is_first;
    in_last_of_burst <= s.is_last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic set_sensitivity(logic signed [SENS_W-1:0] value);
    in_valid <= 1'b0;
    while (awaited_count != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_stream(int n_items);
    sample_t s;
    int sent, len, k;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 85) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(24, 48) : $urandom_range(1, 12);
        for (k = 0; k < len; k++) begin
          s.i = pick_sample();
          s.q = pick_sample();
          s.is_first = (k == 0);
          s.is_last = (k == len - 1);
          send_word(s);
        end
        sent += len;
      end else begin
        s.i = pick_sample();
        s.q = pick_sample();
        s.is_first = 1'($urandom_range(1));
        s.is_last = 1'($urandom_range(1));
        send_word(s);
        sent++;
      end
    end
  endtask

  initial begin
    sample_t directed [$];
    logic signed [SENS_W-1:0] gains [6];
    int seg;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_i = '0;
    in_q = '0;
    in_first_of_burst = 1'b0;
    in_last_of_burst = 1'b0;
    tx_idle_pct = 9;
    rx_idle_pct = 77;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A word without a predecessor, zero products, a first mark inside an
    // open burst, the half-turn clamp, all quadrants and a one-sample burst.
    directed = '{
      '{16'sd100, 16'sd0, 1'b0, 1'b0},       '{16'sd0, 16'sd100, 1'b0, 1'b0},
      '{16'sd0, 16'sd0, 1'b0, 1'b0},         '{16'sd0, 16'sd0, 1'b0, 1'b0},
      '{16'sh7FFF, 16'sd0, 1'b1, 1'b0},      '{16'sh8000, 16'sd0, 1'b0, 1'b0},
      '{16'sh8000, 16'sh8000, 1'b0, 1'b0},   '{16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0},
      '{16'sh8000, 16'sh7FFF, 1'b0, 1'b0},   '{16'sh7FFF, 16'sh8000, 1'b0, 1'b1},
      '{16'sd1234, -16'sd5678, 1'b1, 1'b1},  '{-16'sd1, -16'sd1, 1'b1, 1'b0},
      '{-16'sd1, 16'sd0, 1'b0, 1'b0},        '{16'sd0, -16'sd1, 1'b0, 1'b0},
      '{16'sd1, 16'sd1, 1'b0, 1'b1},         '{16'sh8000, 16'sh8000, 1'b0, 1'b0},
      '{16'sh8000, 16'sh8000, 1'b0, 1'b1},   '{16'sd100, 16'sd0, 1'b1, 1'b0},
      '{-16'sd100, -16'sd1, 1'b0, 1'b0},     '{-16'sd100, 16'sd1, 1'b0, 1'b0},
      '{16'sh7FFF, 16'sh7FFF, 1'b0, 1'b1}
    };
    foreach (directed[n]) send_word(directed[n]);

    gains = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0001, 16'shF000, 16'sh0000};
    gains[5] = SENS_W'($urandom());
    for (seg = 0; seg < 6; seg++) begin
      if (seg < 2) begin
        tx_idle_pct = 9;
        rx_idle_pct = 77;
      end else if (seg < 4) begin
        tx_idle_pct = 77;
        rx_idle_pct = 9;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      set_sensitivity(gains[seg]);
      send_random_stream(SEG_ITEMS);
    end

    in_valid <= 1'b0;
    while (awaited_count != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (fault_count == 0 && awaited_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
